@@ rtl/core/udiv64_pkg.sv @@
// Shared width constants and stage payload type for the restoring divider.
`timescale 1ns / 1ps
`default_nettype none

package udiv64_pkg;

    // Port field width, fixed by the stream format.
    localparam int unsigned FIELD_W = 64;
    // Operand width actually divided (8 to 64); upper input bits are ignored.
    localparam int unsigned WIDTH   = 64;
    // One restoring step per pipeline stage.
    localparam int unsigned STAGES  = WIDTH;

    typedef struct packed {
        logic [WIDTH-1:0] num_quo;  // dividend bits still to enter, quotient bits at the bottom
        logic [WIDTH-1:0] den;
        logic [WIDTH-1:0] rem;
    } stage_t;

endpackage

`default_nettype wire

@@ rtl/core/udiv64_stage.sv @@
// One restoring shift-subtract step with its pipeline register.
`timescale 1ns / 1ps
`default_nettype none

module udiv64_stage (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 en,
    input  wire                 in_valid,
    input  udiv64_pkg::stage_t  in_data,
    output logic                out_valid,
    output udiv64_pkg::stage_t  out_data
);

    logic                         valid_reg;
    udiv64_pkg::stage_t           data_reg;
    udiv64_pkg::stage_t           data_next;
    logic [udiv64_pkg::WIDTH:0]   rem_shift;
    logic [udiv64_pkg::WIDTH:0]   rem_diff;
    logic                         fit;

    // Bring in the next dividend bit; subtract when the divisor fits.
    always_comb begin
        rem_shift = {in_data.rem, in_data.num_quo[udiv64_pkg::WIDTH-1]};
        rem_diff  = rem_shift - {1'b0, in_data.den};
        fit       = rem_shift >= {1'b0, in_data.den};
        data_next.den     = in_data.den;
        data_next.rem     = fit ? rem_diff[udiv64_pkg::WIDTH-1:0]
                                : rem_shift[udiv64_pkg::WIDTH-1:0];
        data_next.num_quo = {in_data.num_quo[udiv64_pkg::WIDTH-2:0], fit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ rtl/core/udiv64_skid.sv @@
// Output register with skid buffer; decouples the pipeline from result back-pressure.
`timescale 1ns / 1ps
`default_nettype none

module udiv64_skid (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            in_valid,
    input  wire  [udiv64_pkg::WIDTH-1:0]   in_data,
    output logic                           in_ready,
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic [udiv64_pkg::WIDTH-1:0]   out_data
);

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [udiv64_pkg::WIDTH-1:0]  out_data_reg;
    logic [udiv64_pkg::WIDTH-1:0]  out_data_next;
    logic                          skid_valid_reg;
    logic                          skid_valid_next;
    logic [udiv64_pkg::WIDTH-1:0]  skid_data_reg;
    logic [udiv64_pkg::WIDTH-1:0]  skid_data_next;
    logic                          out_free;

    assign out_free = out_ready || !out_valid_reg;
    assign in_ready = !skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                // drain the held transfer first
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end else if (in_valid && !skid_valid_reg) begin
            // output stalled: park the arriving result
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid filled without an output stall");

    a_park_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready && out_valid_reg && !out_ready) |=>
            (skid_valid_reg && skid_data_reg == $past(in_data)))
        else $error("result arriving during a stall was not parked");

endmodule

`default_nettype wire

@@ rtl/core/unsigned_divider_64.sv @@
// Each division passes the WIDTH stage registers, then the skid output register.
// One division per cycle while s_tready is high; one restoring step per stage.
// Back-pressure on m_tready freezes the whole pipeline once the skid register fills.
// Reset (aresetn low, synchronous) clears all valid bits; in-flight items are dropped.
// A zero divisor yields an all-ones quotient.
`timescale 1ns / 1ps
`default_nettype none

module unsigned_divider_64 (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [127:0] s_tdata,   // [63:0] dividend, [127:64] divisor
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [63:0]  m_tdata    // [63:0] quotient
);

    localparam int unsigned W = udiv64_pkg::WIDTH;
    localparam int unsigned F = udiv64_pkg::FIELD_W;

    logic                 pipe_en;
    logic                 stage_valid [udiv64_pkg::STAGES+1];
    udiv64_pkg::stage_t   stage_data  [udiv64_pkg::STAGES+1];
    logic [W-1:0]         quo;

    assign s_tready = pipe_en;

    // Stage 0 input: remainder starts clear.
    assign stage_valid[0]        = s_tvalid;
    assign stage_data[0].num_quo = s_tdata[W-1:0];
    assign stage_data[0].den     = s_tdata[F+W-1:F];
    assign stage_data[0].rem     = '0;

    for (genvar i = 0; i < udiv64_pkg::STAGES; i++) begin : g_step
        udiv64_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (stage_valid[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    udiv64_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (stage_valid[udiv64_pkg::STAGES]),
        .in_data   (stage_data[udiv64_pkg::STAGES].num_quo),
        .in_ready  (pipe_en),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (quo)
    );

    assign m_tdata = F'(quo);

endmodule

`default_nettype wire
